FILE: src/sst_pkg.sv
// Shared types, codes and controller/datapath interface structs for the sorted set table.
package sst_pkg;

  // Request codes; any other code is served as a lookup
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] key;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic       found;
    logic [6:0] count;
    logic       status;
  } out_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH_RD,
    ST_SEARCH_CMP,
    ST_DECIDE,
    ST_UP_RD,
    ST_UP_DRAIN,
    ST_PUT_KEY,
    ST_DOWN_RD,
    ST_RESULT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_cmp;
    logic init_up;
    logic init_down;
    logic shift_rd;
    logic shift_up;
    logic put_key;
    logic done;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic lo_lt_hi;
    logic is_ins;
    logic is_rem;
    logic found;
    logic full;
    logic no_up;
    logic no_down;
    logic up_last;
    logic down_last;
  } stat_t;

endpackage

FILE: src/sst_ctrl.sv
// Sequencer for search, shift and result phases of one request.
module sst_ctrl import sst_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state_r, state_nxt;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decide next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH_RD;
        end
      end
      ST_SEARCH_RD: begin
        if (stat.lo_lt_hi) begin
          cmd.srch_rd = 1'b1;
          state_nxt   = ST_SEARCH_CMP;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_SEARCH_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_nxt    = ST_SEARCH_RD;
      end
      ST_DECIDE: begin
        priority if (stat.is_ins && !stat.found && !stat.full) begin
          if (stat.no_up) begin
            state_nxt = ST_PUT_KEY;
          end else begin
            cmd.init_up = 1'b1;
            state_nxt   = ST_UP_RD;
          end
        end else if (stat.is_rem && stat.found && !stat.no_down) begin
          cmd.init_down = 1'b1;
          state_nxt     = ST_DOWN_RD;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_UP_RD: begin
        cmd.shift_rd = 1'b1;
        cmd.shift_up = 1'b1;
        if (stat.up_last) begin
          state_nxt = ST_UP_DRAIN;
        end
      end
      ST_UP_DRAIN: begin
        // last moved entry is written back this cycle
        state_nxt = ST_PUT_KEY;
      end
      ST_PUT_KEY: begin
        cmd.put_key = 1'b1;
        state_nxt   = ST_RESULT;
      end
      ST_DOWN_RD: begin
        cmd.shift_rd = 1'b1;
        if (stat.down_last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        cmd.done  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // Checks
  a_result_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RESULT |=> state_r == ST_IDLE)
    else $error("result state not followed by idle");

  a_start_searches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> state_r == ST_SEARCH_RD)
    else $error("accepted transaction did not enter search");

  a_drain_then_put: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UP_DRAIN |=> state_r == ST_PUT_KEY)
    else $error("drain not followed by key write");

endmodule

FILE: src/sst_dp.sv
// Key memory, search bounds, shift pointer, count and result register.
module sst_dp import sst_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  input  in_t   in_item,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  out_valid,
  output out_t  out_item
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [AW-1:0] STEP_C = AW'(1);

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata_r;
  logic signed [31:0] key_r, key_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [CW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               eq_r, eq_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic               wb_pend_r;
  logic [AW-1:0]      wb_addr_r, wb_addr_nxt;
  out_t               out_r, out_nxt;
  logic               out_valid_r;

  logic [CW-1:0]      mid_w, cnt_m1, lo_p1;
  logic               rd_en, we;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic signed [31:0] wr_data;
  logic               is_ins, is_rem, full, inc, dec;

  assign mid_w  = lo_r + ((hi_r - lo_r) >> 1);
  assign cnt_m1 = cnt_r - ONE_C;
  assign lo_p1  = lo_r + ONE_C;
  assign is_ins = (mode_r == MODE_INSERT);
  assign is_rem = (mode_r == MODE_REMOVE);
  assign full   = (cnt_r == CAP_C);
  assign inc    = is_ins && !eq_r && !full;
  assign dec    = is_rem && eq_r;

  // Report status to the controller
  always_comb begin
    stat.lo_lt_hi  = (lo_r < hi_r);
    stat.is_ins    = is_ins;
    stat.is_rem    = is_rem;
    stat.found     = eq_r;
    stat.full      = full;
    stat.no_up     = (lo_r == cnt_r);
    stat.no_down   = (lo_p1 == cnt_r);
    stat.up_last   = (CW'(idx_r) == lo_r);
    stat.down_last = (CW'(idx_r) == cnt_m1);
  end

  // Select memory port addresses and data
  assign rd_en   = cmd.srch_rd || cmd.shift_rd;
  assign rd_addr = cmd.shift_rd ? idx_r : mid_w[AW-1:0];
  assign we      = wb_pend_r || cmd.put_key;
  assign wr_addr = wb_pend_r ? wb_addr_r : lo_r[AW-1:0];
  assign wr_data = wb_pend_r ? rdata_r : key_r;

  // Read and write the key memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Compute next datapath values
  always_comb begin
    key_nxt     = key_r;
    mode_nxt    = mode_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    eq_nxt      = eq_r;
    idx_nxt     = idx_r;
    wb_addr_nxt = wb_addr_r;
    cnt_nxt     = cnt_r;
    out_nxt     = out_r;
    if (cmd.load) begin
      key_nxt  = in_item.key;
      mode_nxt = in_item.mode;
      lo_nxt   = '0;
      hi_nxt   = cnt_r;
      eq_nxt   = 1'b0;
    end
    if (cmd.srch_rd) begin
      mid_nxt = mid_w;
    end
    // narrow the bounds; keys are distinct, so a hit marks the final position
    if (cmd.srch_cmp) begin
      if (rdata_r < key_r) begin
        lo_nxt = mid_r + ONE_C;
      end else begin
        hi_nxt = mid_r;
      end
      if (rdata_r == key_r) begin
        eq_nxt = 1'b1;
      end
    end
    if (cmd.init_up) begin
      idx_nxt = cnt_m1[AW-1:0];
    end
    if (cmd.init_down) begin
      idx_nxt = lo_p1[AW-1:0];
    end
    // advance the shift pointer and queue the write-back one place over
    if (cmd.shift_rd) begin
      if (cmd.shift_up) begin
        idx_nxt     = idx_r - STEP_C;
        wb_addr_nxt = idx_r + STEP_C;
      end else begin
        idx_nxt     = idx_r + STEP_C;
        wb_addr_nxt = idx_r - STEP_C;
      end
    end
    if (cmd.done) begin
      if (inc) begin
        cnt_nxt = cnt_r + ONE_C;
      end else if (dec) begin
        cnt_nxt = cnt_m1;
      end
      out_nxt.found  = eq_r;
      out_nxt.count  = 7'(cnt_nxt);
      out_nxt.status = is_ins && !eq_r && full;
    end
  end

  // Hold control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      wb_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      wb_pend_r   <= cmd.shift_rd;
      out_valid_r <= cmd.done;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    mode_r    <= mode_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    eq_r      <= eq_nxt;
    idx_r     <= idx_nxt;
    wb_addr_r <= wb_addr_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Checks
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.put_key && wb_pend_r))
    else $error("key write collides with shift write-back");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C)
    else $error("count exceeds capacity");

  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.found && out_r.status))
    else $error("rejected insert reported as member");

endmodule

FILE: src/sorted_set_table_top.sv
// Top level of the sorted set table: controller plus datapath.
//
//  channel | ports                    | handshake
//  --------+--------------------------+-----------------------------------
//  input   | start, busy, in_item     | taken at an edge with start & !busy
//  result  | out_valid, out_item      | one-cycle strobe, always taken
//
// A request is busy through S binary search steps (about log2(count+1)),
// each a read and then a compare, all paid on the single read port of the key
// memory, then a decide state and a result state. An insert of a new key adds a
// shift up of (count - position) entries, a drain and a key write, or only the key
// write when the key lands past the last entry; a remove of a present key adds a
// shift down of (count - position - 1) entries, one entry moved per cycle.
// Reset clears the count at once; no clearing pass runs over the memory.
// The result strobe shows in the first cycle that busy is low again; the receiver never stalls.
module sorted_set_table_top import sst_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  in_item,
  output logic busy,
  output logic out_valid,
  output out_t out_item
);

  cmd_t  cmd;
  stat_t stat;

  sst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: verif/tb_sorted_set_table_top.sv
// Self-checking testbench for the sorted set table: directed and random requests vs a table model.
module tb_sorted_set_table_top;
  import sst_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 120;
  localparam int RANDOM_ITEMS = 700;

  // Code the block serves as a lookup
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;
  logic start;
  in_t  in_item;
  logic busy;
  logic out_valid;
  out_t out_item;

  // Model of the table contents
  logic signed [31:0] table_keys [TABLE_DEPTH];
  int                 table_count;

  // Replies owed by the block, oldest first
  out_t replies_due [$];
  out_t want_reply;
  int   fault_count;
  bit   gaps_on;

  sorted_set_table_top #(
    .CAPACITY (TABLE_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one request to the table model and return the reply it earns
  function automatic out_t apply_to_table(logic [1:0] mode, logic signed [31:0] key);
    int   lo;
    int   hi;
    int   mid;
    int   i;
    bit   hit;
    out_t reply;
    lo = 0;
    hi = table_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < table_count) && (table_keys[lo] == key);
    reply.status = 1'b0;
    if (mode == MODE_INSERT && !hit) begin
      if (table_count >= TABLE_DEPTH) begin
        reply.status = 1'b1;
      end else begin
        for (i = table_count; i > lo; i--) table_keys[i] = table_keys[i - 1];
        table_keys[lo] = key;
        table_count++;
      end
    end else if (mode == MODE_REMOVE && hit) begin
      for (i = lo; i + 1 < table_count; i++) table_keys[i] = table_keys[i + 1];
      table_count--;
    end
    reply.found = hit;
    reply.count = 7'(table_count);
    return reply;
  endfunction

  // Mostly short gaps, a few long ones that span a whole request
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (!gaps_on || r < 60) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(20, 4);
    return $urandom_range(120, 21);
  endfunction

  // Favor held keys, extremes and a tight cluster so hits and duplicates are common
  function automatic logic signed [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30 && table_count > 0) return table_keys[$urandom_range(table_count - 1)];
    if (r < 40) begin
      case ($urandom_range(3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (r < 75) return $signed(32'($urandom_range(200))) - 32'sd100;
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_mode(int unsigned ins_pct, int unsigned rem_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < ins_pct) return MODE_INSERT;
    if (r < ins_pct + rem_pct) return MODE_REMOVE;
    if (r < ins_pct + rem_pct + 4) return MODE_UNUSED;
    return MODE_LOOKUP;
  endfunction

  // Present one transaction and hold it until taken; start stays high afterwards
  task automatic issue_request(logic [1:0] mode, logic signed [31:0] key);
    in_t req;
    req.mode = mode;
    req.key  = key;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    replies_due.push_back(apply_to_table(mode, key));
  endtask

  task automatic hold_off(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drop start and wait for every owed reply
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
  endtask

  task automatic send_with_gap(logic [1:0] mode, logic signed [31:0] key);
    issue_request(mode, key);
    hold_off(pick_gap());
  endtask

  // Extremes, every mode and the simple corner cases on a small table
  task automatic test_directed_basics();
    send_with_gap(MODE_LOOKUP, KEY_MIN);
    send_with_gap(MODE_REMOVE, 32'sd5);
    send_with_gap(MODE_INSERT, 32'sd0);
    send_with_gap(MODE_INSERT, KEY_MAX);
    send_with_gap(MODE_INSERT, KEY_MIN);
    send_with_gap(MODE_INSERT, -32'sd1);
    send_with_gap(MODE_INSERT, 32'sd1);
    send_with_gap(MODE_INSERT, 32'sd0);
    send_with_gap(MODE_LOOKUP, KEY_MAX);
    send_with_gap(MODE_LOOKUP, 32'sd5);
    send_with_gap(MODE_UNUSED, -32'sd1);
    send_with_gap(MODE_UNUSED, 32'sd7);
    send_with_gap(MODE_REMOVE, -32'sd1);
    send_with_gap(MODE_REMOVE, 32'sd7);
    send_with_gap(MODE_REMOVE, KEY_MIN);
    send_with_gap(MODE_REMOVE, KEY_MAX);
    send_with_gap(MODE_LOOKUP, KEY_MIN);
    send_with_gap(MODE_INSERT, 32'sh5555_5555);
    send_with_gap(MODE_INSERT, 32'shaaaa_aaaa);
    send_with_gap(MODE_LOOKUP, 32'sh5555_5555);
    settle();
  endtask

  // Fill to capacity, then probe rejects, duplicates and full-length shifts
  task automatic test_full_table();
    while (table_count < TABLE_DEPTH) send_with_gap(MODE_INSERT, $urandom);
    send_with_gap(MODE_INSERT, KEY_MIN);
    send_with_gap(MODE_INSERT, KEY_MAX);
    send_with_gap(MODE_INSERT, $urandom);
    send_with_gap(MODE_INSERT, table_keys[0]);
    send_with_gap(MODE_INSERT, table_keys[TABLE_DEPTH - 1]);
    send_with_gap(MODE_LOOKUP, table_keys[TABLE_DEPTH / 2]);
    send_with_gap(MODE_REMOVE, table_keys[TABLE_DEPTH - 1]);
    send_with_gap(MODE_INSERT, KEY_MIN);
    send_with_gap(MODE_INSERT, 32'sd3);
    send_with_gap(MODE_REMOVE, table_keys[0]);
    send_with_gap(MODE_INSERT, KEY_MIN);
    settle();
  endtask

  // Random traffic in phases that grow, churn and shrink the table
  task automatic test_random_churn();
    int          n;
    int unsigned ins_pct;
    int unsigned rem_pct;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / 100) % 6)
        0: begin ins_pct = 70; rem_pct = 15; end
        1: begin ins_pct = 40; rem_pct = 40; end
        2: begin ins_pct = 15; rem_pct = 70; end
        3: begin ins_pct = 85; rem_pct = 5;  end
        4: begin ins_pct = 45; rem_pct = 35; end
        default: begin ins_pct = 10; rem_pct = 80; end
      endcase
      // One phase runs with no random gaps between requests
      gaps_on = ((n / 100) != 4);
      if (n % 100 == 0 || $urandom_range(49) == 0) settle();
      send_with_gap(pick_mode(ins_pct, rem_pct), pick_key());
    end
    gaps_on = 1'b1;
    settle();
  endtask

  // Remove everything left, then hit the empty table again
  task automatic test_drain_to_empty();
    while (table_count > 0)
      send_with_gap(MODE_REMOVE, table_keys[$urandom_range(table_count - 1)]);
    send_with_gap(MODE_LOOKUP, KEY_MAX);
    send_with_gap(MODE_REMOVE, KEY_MIN);
    send_with_gap(MODE_INSERT, KEY_MAX);
    settle();
  endtask

  // Compare each result transaction with the oldest owed reply
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        $error("unexpected result: found=%0d count=%0d status=%0d",
               out_item.found, out_item.count, out_item.status);
        fault_count++;
      end else begin
        want_reply = replies_due.pop_front();
        if (out_item.found !== want_reply.found) begin
          $error("found: expected %0d, actual %0d", want_reply.found, out_item.found);
          fault_count++;
        end
        if (out_item.count !== want_reply.count) begin
          $error("count: expected %0d, actual %0d", want_reply.count, out_item.count);
          fault_count++;
        end
        if (out_item.status !== want_reply.status) begin
          $error("status: expected %0d, actual %0d", want_reply.status, out_item.status);
          fault_count++;
        end
      end
    end
  end

  // End the run if no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((rst_n && start && !busy) || (rst_n && out_valid)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    table_count = 0;
    fault_count = 0;
    gaps_on     = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_basics();
    test_full_table();
    test_random_churn();
    test_drain_to_empty();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d replies never arrived", replies_due.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
